// ----- src/assert_macros.svh -----
// Assertion macros shared by the replication factor block.
// Needs nothing else; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PARF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define PARF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/parf_pkg.sv -----
// Types and constants of the popularity adaptive replication factor block.
// Used by the controller, the datapath and the top level.
package parf_pkg;

   // Request commands.
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   // Result kinds.
   localparam logic [2:0] KIND_COUNTED  = 3'd0;
   localparam logic [2:0] KIND_INSERTED = 3'd1;
   localparam logic [2:0] KIND_DROPPED  = 3'd2;
   localparam logic [2:0] KIND_CHANGED  = 3'd3;
   localparam logic [2:0] KIND_CLOSED   = 3'd4;
   localparam logic [2:0] KIND_SKIPPED  = 3'd5;

   // Register indexes and reset values.
   localparam logic [1:0] CSR_K_BASE = 2'd0;
   localparam logic [1:0] CSR_K_MIN  = 2'd1;
   localparam logic [1:0] CSR_K_MAX  = 2'd2;
   localparam logic [1:0] CSR_K_HYST = 2'd3;
   localparam logic [7:0] K_BASE_RST = 8'd10;
   localparam logic [7:0] K_MIN_RST  = 8'd5;
   localparam logic [7:0] K_MAX_RST  = 8'd40;
   localparam logic [7:0] K_HYST_RST = 8'd2;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        cmd;
      logic [63:0] target_hi;
      logic [63:0] target_lo;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [7:0]  k_new;
      logic [31:0] window_mean;
      logic        last;
   } rsp_type;

   // One table entry as stored in the slot memory.
   typedef struct packed {
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [31:0] count;
      logic [7:0]  factor;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       accept;
      logic       idx_clr;
      logic       idx_inc;
      logic       rec_free;
      logic       sum_add;
      logic       div_mean;
      logic       mean_ld;
      logic       ent_ld;
      logic       nk_base;
      logic       e_clr;
      logic       e_inc;
      logic       div_y;
      logic       y_ld;
      logic       sq;
      logic       norm;
      logic       kmul;
      logic       clamp;
      logic       wr_hit;
      logic       wr_new;
      logic       wr_upd;
      logic       emit;
      logic [2:0] emit_kind;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_cmd;
      logic idx_last;
      logic slot_valid;
      logic key_hit;
      logic free_found;
      logic n_zero;
      logic div_done;
      logic mean_zero;
      logic cnt_le_mean;
      logic exp_more;
      logic sq_done;
      logic report;
      logic out_free;
   } sts_type;

endpackage

// ----- src/popularity_adaptive_replication_factor.sv -----
// Top level of the popularity adaptive replication factor block.
// Depends on parf_pkg, parf_ctrl and parf_dp.
//
//   channel   ports                          direction
//   request   req_valid, req_stall, req_data  in (stall out)
//   result    rsp_valid, rsp_stall, rsp_data  out (stall in)
//   registers csr_we, csr_index, csr_wdata    in
//
// A query walks the slot memory one slot after another until a key matches or the table ends.
// A window close sums the counts of the occupied slots, divides the sum by their number
// for the window mean, then visits every slot; for an occupied one whose count is above
// the mean it steps the exponent, divides once more, squares and normalises once per
// fraction bit and multiplies by the base factor.
// Reset clears the valid bits at once; no clearing pass is needed.
// One request is processed at a time; a stalled result holds the walk in place.
module popularity_adaptive_replication_factor #(
   parameter int ENTRIES       = 32,
   parameter int LOG_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  parf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output parf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import parf_pkg::*;

   ctl_type ctl;
   sts_type sts;

   parf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   parf_dp #(.ENTRIES(ENTRIES), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .sts       (sts)
   );
endmodule

// ----- src/parf_ram.sv -----
// Generic single write port RAM with one registered read port.
// Depends on nothing.
module parf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/parf_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing.
module parf_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   shifted;
   logic             ge;

   // One shift and trial subtract per cycle.
   always_comb begin
      shifted = {rem_ff, q_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ----- src/parf_dp.sv -----
// Datapath: slot memory, valid bits, registers, window mean, log2 and factor math.
// Depends on parf_pkg, parf_ram, parf_div and assert_macros.svh.
`include "assert_macros.svh"
module parf_dp #(
   parameter int ENTRIES       = 32,
   parameter int LOG_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  parf_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output parf_pkg::rsp_type rsp_data,
   input  parf_pkg::ctl_type ctl,
   output parf_pkg::sts_type sts
);
   import parf_pkg::*;

   localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int F     = LOG_FRAC_BITS;
   localparam int TW    = 32 + IW;
   localparam int DIV_W = (32 + F > TW) ? 32 + F : TW;
   localparam int SQ_W  = $clog2(F);
   localparam int TM_W  = F + 6;
   localparam int KP_W  = TM_W + 8;

   // Configuration registers.
   logic [7:0] k_base_ff, k_min_ff, k_max_ff, k_hyst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_base_ff <= K_BASE_RST;
         k_min_ff  <= K_MIN_RST;
         k_max_ff  <= K_MAX_RST;
         k_hyst_ff <= K_HYST_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_K_BASE: k_base_ff <= csr_wdata;
            CSR_K_MIN:  k_min_ff  <= csr_wdata;
            CSR_K_MAX:  k_max_ff  <= csr_wdata;
            CSR_K_HYST: k_hyst_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [63:0]      key_hi_ff, key_lo_ff;
   logic             cmd_ff;
   logic [IW-1:0]    idx_ff, free_idx_ff;
   logic             free_found_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [TW-1:0]    total_ff;
   logic [IW:0]      n_ff;
   logic [31:0]      mean_ff;
   entry_type        ent_ff;
   logic [32:0]      den_ff;
   logic [4:0]       e_ff;
   logic [F:0]       y_ff;
   logic [2*F+1:0]   prod_ff;
   logic [F-1:0]     frac_ff;
   logic [SQ_W-1:0]  sq_cnt_ff;
   logic [KP_W-1:0]  kprod_ff;
   logic [7:0]       nk_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic [IW-1:0]    wr_addr;
   logic             wr_en;
   entry_type        rd_ent, wr_ent;
   logic             div_done;
   logic [DIV_W-1:0] div_quot, div_num;
   logic [31:0]      div_den;
   logic [F+1:0]     sq_top;
   logic [TM_W-1:0]  term;
   logic [13:0]      k_raw;
   logic [7:0]       k_clamped, k_diff;
   logic             report, out_free;

   assign rd_ent = entry_type'(rd_data);

   // Slot memory write selection.
   always_comb begin
      wr_en   = ctl.wr_hit | ctl.wr_new | ctl.wr_upd;
      wr_addr = idx_ff;
      wr_ent  = rd_ent;
      if (ctl.wr_hit) begin
         wr_ent.count = (rd_ent.count == COUNT_MAX) ? rd_ent.count : rd_ent.count + 32'd1;
      end else if (ctl.wr_new) begin
         wr_addr = free_idx_ff;
         wr_ent  = '{key_hi: key_hi_ff, key_lo: key_lo_ff, count: 32'd1, factor: k_base_ff};
      end else begin
         wr_ent        = ent_ff;
         wr_ent.count  = '0;
         wr_ent.factor = report ? nk_ff : ent_ff.factor;
      end
      wr_data = wr_ent;
   end

   parf_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Shared divider: window mean and log2 mantissa.
   assign div_num = ctl.div_mean ? DIV_W'(total_ff) : DIV_W'({ent_ff.count, {F{1'b0}}});
   assign div_den = ctl.div_mean ? 32'(n_ff) : den_ff[31:0];

   parf_div #(.NUM_W(DIV_W), .DEN_W(32)) u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_mean | ctl.div_y),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Factor arithmetic.
   assign sq_top = prod_ff[2*F+1:F];
   assign term   = TM_W'({e_ff, frac_ff}) + (TM_W'(1) << F);
   assign k_raw  = kprod_ff[F+13:F];
   always_comb begin
      if (k_raw < 14'(k_min_ff)) begin
         k_clamped = k_min_ff;
      end else if (k_raw > 14'(k_max_ff)) begin
         k_clamped = k_max_ff;
      end else begin
         k_clamped = k_raw[7:0];
      end
      k_diff = (nk_ff >= ent_ff.factor) ? nk_ff - ent_ff.factor : ent_ff.factor - nk_ff;
      report = k_diff >= k_hyst_ff;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Control registers of the table walk.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         valid_ff      <= '0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctl.accept || ctl.idx_clr) begin
            idx_ff <= '0;
         end else if (ctl.idx_inc) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (ctl.accept) begin
            free_found_ff <= 1'b0;
         end else if (ctl.rec_free && !valid_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
         if (ctl.wr_new) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff    <= req_data.cmd;
         key_hi_ff <= req_data.target_hi;
         key_lo_ff <= req_data.target_lo;
         total_ff  <= '0;
         n_ff      <= '0;
      end else if (ctl.sum_add && valid_ff[idx_ff]) begin
         total_ff <= total_ff + TW'(rd_ent.count);
         n_ff     <= n_ff + (IW+1)'(1);
      end
      if (ctl.rec_free && !valid_ff[idx_ff] && !free_found_ff) begin
         free_idx_ff <= idx_ff;
      end
      if (ctl.mean_ld) begin
         mean_ff <= div_quot[31:0];
      end
      if (ctl.ent_ld) begin
         ent_ff <= rd_ent;
      end
      if (ctl.e_clr) begin
         e_ff   <= '0;
         den_ff <= {1'b0, mean_ff};
      end else if (ctl.e_inc) begin
         e_ff   <= e_ff + 5'd1;
         den_ff <= {den_ff[31:0], 1'b0};
      end
      if (ctl.y_ld) begin
         y_ff      <= div_quot[F:0];
         frac_ff   <= '0;
         sq_cnt_ff <= '0;
      end else if (ctl.norm) begin
         y_ff      <= sq_top[F+1] ? sq_top[F+1:1] : sq_top[F:0];
         frac_ff   <= {frac_ff[F-2:0], sq_top[F+1]};
         sq_cnt_ff <= sq_cnt_ff + SQ_W'(1);
      end
      if (ctl.sq) begin
         prod_ff <= y_ff * y_ff;
      end
      if (ctl.kmul) begin
         kprod_ff <= KP_W'(k_base_ff) * KP_W'(term);
      end
      if (ctl.nk_base) begin
         nk_ff <= k_base_ff;
      end else if (ctl.clamp) begin
         nk_ff <= k_clamped;
      end
      if (ctl.emit) begin
         rsp_ff.kind        <= ctl.emit_kind;
         rsp_ff.k_new       <= '0;
         rsp_ff.window_mean <= '0;
         rsp_ff.last        <= 1'b1;
         rsp_ff.key_hi      <= '0;
         rsp_ff.key_lo      <= '0;
         case (ctl.emit_kind)
            KIND_COUNTED, KIND_INSERTED, KIND_DROPPED: begin
               rsp_ff.key_hi <= key_hi_ff;
               rsp_ff.key_lo <= key_lo_ff;
            end
            KIND_CHANGED: begin
               rsp_ff.key_hi <= ent_ff.key_hi;
               rsp_ff.key_lo <= ent_ff.key_lo;
               rsp_ff.k_new  <= nk_ff;
               rsp_ff.last   <= 1'b0;
            end
            KIND_CLOSED: begin
               rsp_ff.window_mean <= mean_ff;
            end
            default: ;
         endcase
      end
   end

   // Status back to the controller.
   always_comb begin
      sts.req_cmd     = req_data.cmd;
      sts.idx_last    = idx_ff == IW'(ENTRIES - 1);
      sts.slot_valid  = valid_ff[idx_ff];
      sts.key_hit     = valid_ff[idx_ff] && rd_ent.key_hi == key_hi_ff
                        && rd_ent.key_lo == key_lo_ff && cmd_ff == CMD_QUERY;
      sts.free_found  = free_found_ff;
      sts.n_zero      = n_ff == '0;
      sts.div_done    = div_done;
      sts.mean_zero   = mean_ff == '0;
      sts.cnt_le_mean = rd_ent.count <= mean_ff;
      sts.exp_more    = (e_ff != 5'd31) && ({den_ff, 1'b0} <= {2'b00, ent_ff.count});
      sts.sq_done     = sq_cnt_ff == SQ_W'(F - 1);
      sts.report      = report;
      sts.out_free    = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PARF_ASSERT(a_emit_free, clock, reset, !ctl.emit || out_free, "result written over a waiting one")
   `PARF_ASSERT(a_new_has_slot, clock, reset, !ctl.wr_new || free_found_ff, "insert without free slot")
   `PARF_ASSERT(a_one_write, clock, reset, $onehot0({ctl.wr_hit, ctl.wr_new, ctl.wr_upd}), "two slot writes at once")
endmodule

// ----- src/parf_ctrl.sv -----
// Controller state machine: sequences table walks, the divider and the factor steps.
// Depends on parf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module parf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  parf_pkg::sts_type sts,
   output parf_pkg::ctl_type ctl
);
   import parf_pkg::*;

   typedef enum logic [4:0] {
      IDLE, Q_RD, Q_CMP, Q_HIT, Q_END,
      C_RD, C_SUM, C_DIVS, C_DIVW, C_CHK, C_SKIP,
      U_RD, U_LD, U_EXP, U_YDIV, U_SQ, U_NORM, U_MUL, U_CLAMP, U_CMP, C_FIN
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = (sts.req_cmd == CMD_CLOSE) ? C_RD : Q_RD;
            end
         end
         Q_RD: state_in = Q_CMP;
         Q_CMP: begin
            if (sts.key_hit) begin
               state_in = Q_HIT;
            end else begin
               ctl.rec_free = 1'b1;
               if (sts.idx_last) begin
                  state_in = Q_END;
               end else begin
                  ctl.idx_inc = 1'b1;
                  state_in    = Q_RD;
               end
            end
         end
         Q_HIT: begin
            if (sts.out_free) begin
               ctl.wr_hit    = 1'b1;
               ctl.emit      = 1'b1;
               ctl.emit_kind = KIND_COUNTED;
               state_in      = IDLE;
            end
         end
         Q_END: begin
            if (sts.out_free) begin
               ctl.wr_new    = sts.free_found;
               ctl.emit      = 1'b1;
               ctl.emit_kind = sts.free_found ? KIND_INSERTED : KIND_DROPPED;
               state_in      = IDLE;
            end
         end
         C_RD: state_in = C_SUM;
         C_SUM: begin
            ctl.sum_add = 1'b1;
            if (sts.idx_last) begin
               state_in = C_DIVS;
            end else begin
               ctl.idx_inc = 1'b1;
               state_in    = C_RD;
            end
         end
         C_DIVS: begin
            if (sts.n_zero) begin
               state_in = C_SKIP;
            end else begin
               ctl.div_mean = 1'b1;
               state_in     = C_DIVW;
            end
         end
         C_DIVW: begin
            if (sts.div_done) begin
               ctl.mean_ld = 1'b1;
               state_in    = C_CHK;
            end
         end
         C_CHK: begin
            if (sts.mean_zero) begin
               state_in = C_SKIP;
            end else begin
               ctl.idx_clr = 1'b1;
               state_in    = U_RD;
            end
         end
         C_SKIP: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.emit_kind = KIND_SKIPPED;
               state_in      = IDLE;
            end
         end
         U_RD: state_in = U_LD;
         U_LD: begin
            if (!sts.slot_valid) begin
               if (sts.idx_last) begin
                  state_in = C_FIN;
               end else begin
                  ctl.idx_inc = 1'b1;
                  state_in    = U_RD;
               end
            end else begin
               ctl.ent_ld = 1'b1;
               if (sts.cnt_le_mean) begin
                  ctl.nk_base = 1'b1;
                  state_in    = U_CMP;
               end else begin
                  ctl.e_clr = 1'b1;
                  state_in  = U_EXP;
               end
            end
         end
         U_EXP: begin
            if (sts.exp_more) begin
               ctl.e_inc = 1'b1;
            end else begin
               ctl.div_y = 1'b1;
               state_in  = U_YDIV;
            end
         end
         U_YDIV: begin
            if (sts.div_done) begin
               ctl.y_ld = 1'b1;
               state_in = U_SQ;
            end
         end
         U_SQ: begin
            ctl.sq   = 1'b1;
            state_in = U_NORM;
         end
         U_NORM: begin
            ctl.norm = 1'b1;
            state_in = sts.sq_done ? U_MUL : U_SQ;
         end
         U_MUL: begin
            ctl.kmul = 1'b1;
            state_in = U_CLAMP;
         end
         U_CLAMP: begin
            ctl.clamp = 1'b1;
            state_in  = U_CMP;
         end
         U_CMP: begin
            if (!sts.report || sts.out_free) begin
               ctl.wr_upd    = 1'b1;
               ctl.emit      = sts.report;
               ctl.emit_kind = KIND_CHANGED;
               if (sts.idx_last) begin
                  state_in = C_FIN;
               end else begin
                  ctl.idx_inc = 1'b1;
                  state_in    = U_RD;
               end
            end
         end
         C_FIN: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.emit_kind = KIND_CLOSED;
               state_in      = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != IDLE;

   `PARF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request taken while controller stays idle")
endmodule
